// ----- rtl/vhfm_pkg.sv -----
`default_nettype none
package vhfm_pkg;

	localparam int X_SIZE_DEF = 64;
	localparam int Y_SIZE_DEF = 256;
	localparam int Z_SIZE_DEF = 64;

	localparam int X_W    = 6;
	localparam int Y_W    = 8;
	localparam int Z_W    = 6;
	localparam int ADDR_W = X_W + Y_W + Z_W;
	localparam int CNT_W  = 2;
	localparam int MASK_W = 6;

	typedef logic [X_W-1:0]    x_t;
	typedef logic [Y_W-1:0]    y_t;
	typedef logic [Z_W-1:0]    z_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [MASK_W-1:0] mask_t;

	localparam cnt_t COUNT_MAX = 2'd2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_INS_WR,
		ST_Q_LAST,
		ST_EMIT
	} state_t;

	// Read order of a query; a neighbour step code minus one is its mask bit.
	typedef enum logic [2:0] {
		STEP_OWN,
		STEP_ZP,
		STEP_ZN,
		STEP_XP,
		STEP_XN,
		STEP_YP,
		STEP_YN
	} step_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		cnt_t  data;
	} mem_wr_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} mem_rd_t;

	typedef struct packed {
		logic  valid;
		mask_t mask;
	} res_t;

	typedef struct packed {
		logic  valid;
		logic  ok;
		step_t step;
	} pend_t;

endpackage
`default_nettype wire

// ----- rtl/voxel_hidden_face_mask.sv -----
// Flow: an insert is accepted in ST_IDLE, read in ST_READ and written back in
// ST_INS_WR; a query reads the cell and its six neighbours one per cycle through
// the single read port of the count memory in ST_READ, passes ST_Q_LAST and ST_EMIT,
// then its word shows on m_tvalid. A new word is taken only after the last is done.
// Reset: arst_n clears control state, then a clearing pass writes zero to all
// 1,048,576 count entries, one a cycle, before s_tready first rises.
`default_nettype none
module voxel_hidden_face_mask #(
	parameter int X_SIZE = vhfm_pkg::X_SIZE_DEF,
	parameter int Y_SIZE = vhfm_pkg::Y_SIZE_DEF,
	parameter int Z_SIZE = vhfm_pkg::Z_SIZE_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // [5:0] pos_x, [13:6] pos_y, [19:14] pos_z, rest zero
	input  wire         s_tuser,   // [0] action
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata    // [5:0] face_mask, rest zero
);

	vhfm_pkg::mem_wr_t wr;
	vhfm_pkg::mem_rd_t rd;
	vhfm_pkg::cnt_t    rd_data;
	vhfm_pkg::res_t    res;
	vhfm_pkg::mask_t   mask_q;
	logic              m_valid_q;
	logic              out_free;

	// The output register takes a new word when empty or emptied this cycle.
	assign out_free = !m_valid_q || m_tready;

	vhfm_ctrl #(
		.X_SIZE (X_SIZE),
		.Y_SIZE (Y_SIZE),
		.Z_SIZE (Z_SIZE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tuser),
		.in_x      (s_tdata[5:0]),
		.in_y      (s_tdata[13:6]),
		.in_z      (s_tdata[19:14]),
		.wr        (wr),
		.rd        (rd),
		.rd_data   (rd_data),
		.out_free  (out_free),
		.res       (res)
	);

	vhfm_count_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			mask_q <= res.mask;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, mask_q};

endmodule
`default_nettype wire

// ----- rtl/vhfm_count_ram.sv -----
`default_nettype none
module vhfm_count_ram (
	input  wire                    clk,
	input  vhfm_pkg::mem_wr_t      wr,
	input  vhfm_pkg::mem_rd_t      rd,
	output vhfm_pkg::cnt_t         rd_data
);

	localparam int DEPTH = 1 << vhfm_pkg::ADDR_W;

	vhfm_pkg::cnt_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/vhfm_ctrl.sv -----
`default_nettype none
module vhfm_ctrl #(
	parameter int X_SIZE = vhfm_pkg::X_SIZE_DEF,
	parameter int Y_SIZE = vhfm_pkg::Y_SIZE_DEF,
	parameter int Z_SIZE = vhfm_pkg::Z_SIZE_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire                    in_action,
	input  vhfm_pkg::x_t           in_x,
	input  vhfm_pkg::y_t           in_y,
	input  vhfm_pkg::z_t           in_z,
	output vhfm_pkg::mem_wr_t      wr,
	output vhfm_pkg::mem_rd_t      rd,
	input  vhfm_pkg::cnt_t         rd_data,
	input  wire                    out_free,
	output vhfm_pkg::res_t         res
);

	vhfm_pkg::state_t  state_q, state_d;
	vhfm_pkg::step_t   step_q, step_d;
	vhfm_pkg::addr_t   clr_addr_q;
	vhfm_pkg::pend_t   pend_s1, pend_d;
	logic              act_q;
	vhfm_pkg::x_t      x_q, nb_x;
	vhfm_pkg::y_t      y_q, nb_y;
	vhfm_pkg::z_t      z_q, nb_z;
	vhfm_pkg::cnt_t    own_q, cnt;
	vhfm_pkg::mask_t   mask_q;
	logic              nb_ok, x_in, y_in, z_in, accept;
	logic [2:0]        bit_idx;
	logic [vhfm_pkg::CNT_W:0] pair_sum;

	assign accept = in_valid && in_ready;
	assign x_in   = 32'(x_q) < 32'(X_SIZE);
	assign y_in   = 32'(y_q) < 32'(Y_SIZE);
	assign z_in   = 32'(z_q) < 32'(Z_SIZE);

	// Neighbour address and whether it lies in the grid and in the field range.
	always_comb begin
		nb_x  = x_q;
		nb_y  = y_q;
		nb_z  = z_q;
		nb_ok = x_in && y_in && z_in;
		unique case (step_q)
			vhfm_pkg::STEP_OWN: begin
			end
			vhfm_pkg::STEP_ZP: begin
				nb_z  = z_q + vhfm_pkg::z_t'(1);
				nb_ok = x_in && y_in && (z_q != '1) && (32'(z_q) + 32'd1 < 32'(Z_SIZE));
			end
			vhfm_pkg::STEP_ZN: begin
				nb_z  = z_q - vhfm_pkg::z_t'(1);
				nb_ok = x_in && y_in && (z_q != '0) && (32'(z_q) <= 32'(Z_SIZE));
			end
			vhfm_pkg::STEP_XP: begin
				nb_x  = x_q + vhfm_pkg::x_t'(1);
				nb_ok = y_in && z_in && (x_q != '1) && (32'(x_q) + 32'd1 < 32'(X_SIZE));
			end
			vhfm_pkg::STEP_XN: begin
				nb_x  = x_q - vhfm_pkg::x_t'(1);
				nb_ok = y_in && z_in && (x_q != '0) && (32'(x_q) <= 32'(X_SIZE));
			end
			vhfm_pkg::STEP_YP: begin
				nb_y  = y_q + vhfm_pkg::y_t'(1);
				nb_ok = x_in && z_in && (y_q != '1) && (32'(y_q) + 32'd1 < 32'(Y_SIZE));
			end
			vhfm_pkg::STEP_YN: begin
				nb_y  = y_q - vhfm_pkg::y_t'(1);
				nb_ok = x_in && z_in && (y_q != '0) && (32'(y_q) <= 32'(Y_SIZE));
			end
			default: begin
			end
		endcase
	end

	// Data of the read issued last cycle; cells off the grid count as empty.
	assign cnt      = pend_s1.ok ? rd_data : '0;
	assign pair_sum = {1'b0, own_q} + {1'b0, cnt};
	assign bit_idx  = 3'(pend_s1.step) - 3'd1;

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		pend_d   = '0;
		in_ready = 1'b0;
		rd       = '0;
		wr       = '0;
		res      = '0;
		unique case (state_q)
			vhfm_pkg::ST_CLEAR: begin
				wr.en   = 1'b1;
				wr.addr = clr_addr_q;
				wr.data = '0;
				if (&clr_addr_q) begin
					state_d = vhfm_pkg::ST_IDLE;
				end
			end
			vhfm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					step_d  = vhfm_pkg::STEP_OWN;
					state_d = vhfm_pkg::ST_READ;
				end
			end
			vhfm_pkg::ST_READ: begin
				rd.en       = 1'b1;
				rd.addr     = {nb_y, nb_z, nb_x};
				pend_d.valid = 1'b1;
				pend_d.ok    = nb_ok;
				pend_d.step  = step_q;
				if (act_q == vhfm_pkg::ACT_INSERT) begin
					state_d = vhfm_pkg::ST_INS_WR;
				end else if (step_q == vhfm_pkg::STEP_YN) begin
					state_d = vhfm_pkg::ST_Q_LAST;
				end else begin
					step_d = vhfm_pkg::step_t'(step_q + 3'd1);
				end
			end
			vhfm_pkg::ST_INS_WR: begin
				wr.en   = pend_s1.ok && (rd_data < vhfm_pkg::COUNT_MAX);
				wr.addr = {y_q, z_q, x_q};
				wr.data = rd_data + vhfm_pkg::cnt_t'(1);
				state_d = vhfm_pkg::ST_IDLE;
			end
			vhfm_pkg::ST_Q_LAST: begin
				state_d = vhfm_pkg::ST_EMIT;
			end
			vhfm_pkg::ST_EMIT: begin
				if (out_free) begin
					res.valid = 1'b1;
					res.mask  = mask_q;
					state_d   = vhfm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vhfm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= vhfm_pkg::ST_CLEAR;
			step_q     <= vhfm_pkg::STEP_OWN;
			clr_addr_q <= '0;
			pend_s1    <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			pend_s1 <= pend_d;
			if (state_q == vhfm_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + vhfm_pkg::addr_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= in_action;
			x_q    <= in_x;
			y_q    <= in_y;
			z_q    <= in_z;
			mask_q <= '0;
		end else if (pend_s1.valid) begin
			if (pend_s1.step == vhfm_pkg::STEP_OWN) begin
				own_q <= cnt;
			end else begin
				mask_q[bit_idx] <= (pair_sum >= 3'd2);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_write_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vhfm_pkg::ST_READ) |-> !wr.en)
		else $error("count store written while a word is being read");

	a_result_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result pushed into a full output register");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vhfm_pkg::ST_CLEAR && (&clr_addr_q)) |=> (state_q == vhfm_pkg::ST_IDLE))
		else $error("clearing pass did not end at the last entry");

	a_insert_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vhfm_pkg::ST_INS_WR && wr.en) |-> (wr.data != '0 && wr.data <= vhfm_pkg::COUNT_MAX))
		else $error("insert wrote a count out of range");

	a_insert_one_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vhfm_pkg::ST_INS_WR) |-> (pend_s1.valid && pend_s1.step == vhfm_pkg::STEP_OWN))
		else $error("insert write without the cell's own read");
`endif

endmodule
`default_nettype wire
